// ===== sv/trnc_pkg.sv =====
// ----------------------------------------------------------------------------
// Token ring node controller package
// Shared types, codes and helpers for the station controller.
// ----------------------------------------------------------------------------
package trnc_pkg;

  // Send queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result FIFO geometry. Room for two results is checked before each item.
  localparam int RF_DEPTH = 4;
  localparam int RF_PTR_W = 2;
  localparam int RF_CNT_W = 3;

  // Operation codes.
  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_HOST  = 2'd1;
  localparam logic [1:0] OP_QUEUE = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Packet type codes.
  localparam logic [1:0] PT_ID    = 2'd0;
  localparam logic [1:0] PT_SIZE  = 2'd1;
  localparam logic [1:0] PT_TOKEN = 2'd2;
  localparam logic [1:0] PT_DATA  = 2'd3;

  // Result port codes.
  localparam logic [1:0] PORT_SEND    = 2'd0;
  localparam logic [1:0] PORT_DELIVER = 2'd1;
  localparam logic [1:0] PORT_REJECT  = 2'd2;

  // Fixed packet values.
  localparam logic [7:0] BCAST_ID    = 8'hFF;
  localparam logic [7:0] LEN_INIT    = 8'd3;
  localparam logic [7:0] LEN_TOKEN   = 8'd2;
  localparam logic [7:0] LEN_HDR     = 8'd3;
  localparam logic [7:0] FIRST_ID    = 8'd1;

  // One input item.
  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  pkt_type;
    logic [7:0]  pkt_value;
    logic [7:0]  pkt_src;
    logic [7:0]  pkt_dest;
    logic [15:0] payload_handle;
    logic [7:0]  pkt_length;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  out_port;
    logic [1:0]  out_type;
    logic [7:0]  out_value;
    logic [7:0]  out_src;
    logic [7:0]  out_dest;
    logic [15:0] out_handle;
    logic [7:0]  out_length;
    logic        out_last;
    logic [1:0]  node_state;
    logic [7:0]  node_id;
    logic [7:0]  ring_size_now;
    logic [15:0] tokens_seen;
  } out_t;

  // Up to two results written into the result FIFO in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       ent1;
    out_t       ent0;
  } res_wr_t;

  // Builds a result with the packet fields set and the status fields clear.
  function automatic out_t mk_res(input logic [1:0]  port,
                                  input logic [1:0]  ptype,
                                  input logic [7:0]  value,
                                  input logic [7:0]  src,
                                  input logic [7:0]  dest,
                                  input logic [15:0] handle,
                                  input logic [7:0]  length);
    out_t r;
    r            = '0;
    r.out_port   = port;
    r.out_type   = ptype;
    r.out_value  = value;
    r.out_src    = src;
    r.out_dest   = dest;
    r.out_handle = handle;
    r.out_length = length;
    return r;
  endfunction

endpackage

// ===== sv/token_ring_node_controller_unit.sv =====
// Flow: with room in the result FIFO, an item passes from the input register
// through the station core, and its results are registered into the result FIFO.
// Throughput: one item per cycle while the result FIFO has room; results leave
// at one per cycle through the four-entry result FIFO while out_stall is low.
// The input register holds one item and stalls while the FIFO lacks room for two.
// Reset: synchronous, active low; the station comes up pre-init with an empty
// send queue, and queue entries hold no value until written.
// ----------------------------------------------------------------------------
// Token ring node controller
// Input register, station core and result FIFO for packet descriptors.
// ----------------------------------------------------------------------------
module token_ring_node_controller_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  trnc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output trnc_pkg::out_t out_data
);
  import trnc_pkg::*;

  in_t     item_r;
  logic    item_vld_r, item_vld_nxt;
  logic    room;
  logic    go;
  logic    in_xfer;
  res_wr_t res;

  // The held item runs when the FIFO can take both of its results.
  assign go       = item_vld_r && room;
  assign in_stall = item_vld_r && !room;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_xfer) begin
      item_vld_nxt = 1'b1;
    end else if (go) begin
      item_vld_nxt = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
  end

  trnc_station u_station (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item_r),
    .res   (res)
  );

  trnc_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && !go |=> item_vld_r && $stable(item_r))
    else $error("held item lost before it was processed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_vld_r && !room)
    else $error("input stalled with no reason");

  a_results_need_item: assert property (@(posedge clk) disable iff (!rst_n)
    res.cnt != 2'd0 |-> go)
    else $error("results produced without an item");
`endif

endmodule

// ===== sv/trnc_station.sv =====
// ----------------------------------------------------------------------------
// Token ring station core
// Holds the station state and send queue and turns one item into results.
// ----------------------------------------------------------------------------
module trnc_station (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  trnc_pkg::in_t    item,
  output trnc_pkg::res_wr_t res
);
  import trnc_pkg::*;

  typedef enum logic [1:0] {
    ST_PRE   = 2'd0,
    ST_INIT  = 2'd1,
    ST_WAIT  = 2'd2,
    ST_TOKEN = 2'd3
  } st_t;

  typedef struct packed {
    logic [7:0]  src;
    logic [7:0]  dest;
    logic [15:0] handle;
    logic [7:0]  length;
  } qent_t;

  st_t               st_r, st_nxt;
  logic [7:0]        id_r, id_nxt;
  logic              host_r, host_nxt;
  logic [7:0]        size_r, size_nxt;
  logic [15:0]       tally_r, tally_nxt;
  logic [QCNT_W-1:0] q_count_r, q_count_nxt;
  logic [QPTR_W-1:0] q_head_r, q_head_nxt;
  logic [QPTR_W-1:0] q_tail_r, q_tail_nxt;
  logic              q_we;
  qent_t             q_wdata;
  qent_t             q_mem [QUEUE_DEPTH];
  qent_t             q_rdata;
  logic              q_full;
  out_t              r0, r1;
  logic [1:0]        n;

  // Wrapping pointer increment for any queue depth.
  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign q_rdata = q_mem[q_head_r];
  assign q_full  = (q_count_r == QCNT_W'(QUEUE_DEPTH));

  // Decode the item, work out the next state and the results.
  always_comb begin
    st_nxt      = st_r;
    id_nxt      = id_r;
    host_nxt    = host_r;
    size_nxt    = size_r;
    tally_nxt   = tally_r;
    q_count_nxt = q_count_r;
    q_head_nxt  = q_head_r;
    q_tail_nxt  = q_tail_r;
    q_we        = 1'b0;
    q_wdata     = '{src: id_r, dest: item.pkt_dest, handle: item.payload_handle,
                    length: item.pkt_length};
    r0          = '0;
    r1          = '0;
    n           = 2'd0;

    unique case (item.operation)
      OP_RX: begin
        unique case (item.pkt_type)
          PT_ID: begin
            if (host_r) begin
              // The id packet came back around: its value is the ring size.
              if (st_r == ST_INIT) begin
                st_nxt    = ST_TOKEN;
                tally_nxt = tally_r + 16'd1;
                size_nxt  = item.pkt_value;
                r0 = mk_res(PORT_SEND, PT_SIZE, item.pkt_value, 8'd0, 8'd0, 16'd0,
                            LEN_INIT);
                n  = 2'd1;
              end
            end else if (st_r == ST_PRE && item.pkt_value != 8'd0 &&
                         item.pkt_value != BCAST_ID) begin
              st_nxt = ST_INIT;
              id_nxt = item.pkt_value;
              r0 = mk_res(PORT_SEND, PT_ID, item.pkt_value + 8'd1, 8'd0, 8'd0, 16'd0,
                          LEN_INIT);
              n  = 2'd1;
            end
          end
          PT_SIZE: begin
            if (!host_r && st_r == ST_INIT) begin
              st_nxt   = ST_WAIT;
              size_nxt = item.pkt_value;
              r0 = mk_res(PORT_SEND, PT_SIZE, item.pkt_value, 8'd0, 8'd0, 16'd0,
                          LEN_INIT);
              n  = 2'd1;
            end
          end
          PT_TOKEN: begin
            st_nxt    = ST_TOKEN;
            tally_nxt = tally_r + 16'd1;
          end
          PT_DATA: begin
            // Data is handled once the ring is up; our own packets are dropped.
            if ((st_r == ST_WAIT || st_r == ST_TOKEN) && item.pkt_src != id_r) begin
              r0 = mk_res(PORT_DELIVER, PT_DATA, 8'd0, item.pkt_src, item.pkt_dest,
                          item.payload_handle, item.pkt_length);
              r1 = mk_res(PORT_SEND, PT_DATA, 8'd0, item.pkt_src, item.pkt_dest,
                          item.payload_handle, item.pkt_length);
              if (item.pkt_dest == id_r) begin
                n = 2'd1;
              end else if (item.pkt_dest == BCAST_ID) begin
                n = 2'd2;
              end else begin
                r0 = r1;
                r1 = '0;
                n  = 2'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      OP_HOST: begin
        if (st_r == ST_PRE) begin
          st_nxt   = ST_INIT;
          id_nxt   = 8'd0;
          host_nxt = 1'b1;
          r0 = mk_res(PORT_SEND, PT_ID, FIRST_ID, 8'd0, 8'd0, 16'd0, LEN_INIT);
          n  = 2'd1;
        end
      end
      OP_QUEUE: begin
        // Requests without data bytes are ignored.
        if (item.pkt_length > LEN_HDR) begin
          if (q_full) begin
            r0 = mk_res(PORT_REJECT, PT_DATA, 8'd0, id_r, item.pkt_dest,
                        item.payload_handle, item.pkt_length);
            n  = 2'd1;
          end else begin
            q_we        = 1'b1;
            q_tail_nxt  = ptr_inc(q_tail_r);
            q_count_nxt = q_count_r + QCNT_W'(1);
          end
        end
      end
      OP_TICK: begin
        // The token holder sends one queued packet if there is one, then passes the token.
        if (st_r == ST_TOKEN) begin
          st_nxt = ST_WAIT;
          if (q_count_r != '0) begin
            r0 = mk_res(PORT_SEND, PT_DATA, 8'd0, q_rdata.src, q_rdata.dest,
                        q_rdata.handle, q_rdata.length);
            r1 = mk_res(PORT_SEND, PT_TOKEN, 8'd0, 8'd0, 8'd0, 16'd0, LEN_TOKEN);
            n  = 2'd2;
            q_head_nxt  = ptr_inc(q_head_r);
            q_count_nxt = q_count_r - QCNT_W'(1);
          end else begin
            r0 = mk_res(PORT_SEND, PT_TOKEN, 8'd0, 8'd0, 8'd0, 16'd0, LEN_TOKEN);
            n  = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    // Status after the item goes on every result; mark the last one.
    r0.node_state    = 2'(st_nxt);
    r0.node_id       = id_nxt;
    r0.ring_size_now = size_nxt;
    r0.tokens_seen   = tally_nxt;
    r1.node_state    = 2'(st_nxt);
    r1.node_id       = id_nxt;
    r1.ring_size_now = size_nxt;
    r1.tokens_seen   = tally_nxt;
    r0.out_last      = (n == 2'd1);
    r1.out_last      = (n == 2'd2);
  end

  assign res = '{cnt: (go ? n : 2'd0), ent1: r1, ent0: r0};

  // Station control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_PRE;
      id_r      <= '0;
      host_r    <= 1'b0;
      size_r    <= '0;
      tally_r   <= '0;
      q_count_r <= '0;
      q_head_r  <= '0;
      q_tail_r  <= '0;
    end else if (go) begin
      st_r      <= st_nxt;
      id_r      <= id_nxt;
      host_r    <= host_nxt;
      size_r    <= size_nxt;
      tally_r   <= tally_nxt;
      q_count_r <= q_count_nxt;
      q_head_r  <= q_head_nxt;
      q_tail_r  <= q_tail_nxt;
    end
  end

  // Send queue storage; entries are only read once written.
  always_ff @(posedge clk) begin
    if (go && q_we) begin
      q_mem[q_tail_r] <= q_wdata;
    end
  end

`ifndef SYNTHESIS
  a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("send queue count above depth");

  a_tick_emits: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.operation == OP_TICK && st_r == ST_TOKEN |-> res.cnt != 2'd0)
    else $error("token holder tick produced no transfer");

  a_tally_with_token: assert property (@(posedge clk) disable iff (!rst_n)
    go && tally_nxt != tally_r |=> st_r == ST_TOKEN)
    else $error("token tally moved without taking the token");

  a_qhead_moves: assert property (@(posedge clk) disable iff (!rst_n)
    go && q_head_nxt != q_head_r |-> res.cnt == 2'd2)
    else $error("queue head advanced without sending a packet");
`endif

endmodule

// ===== sv/trnc_res_fifo.sv =====
// ----------------------------------------------------------------------------
// Result FIFO
// Takes up to two results per cycle and hands them out one per transfer.
// ----------------------------------------------------------------------------
module trnc_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  trnc_pkg::res_wr_t wr,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output trnc_pkg::out_t    out_data
);
  import trnc_pkg::*;

  out_t                mem_r [RF_DEPTH];
  logic [RF_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RF_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RF_CNT_W-1:0] count_r, count_nxt;
  logic                pop;

  // Room for a full pair of results, judged on registered state only.
  assign room      = (count_r <= RF_CNT_W'(RF_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RF_PTR_W'(wr.cnt);
    rd_ptr_nxt = rd_ptr_r + RF_PTR_W'(pop);
    count_nxt  = count_r + RF_CNT_W'(wr.cnt) - RF_CNT_W'(pop);
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage: first result at the write pointer, second right after.
  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wr.ent0;
    end
    if (wr.cnt == 2'd2) begin
      mem_r[wr_ptr_r + RF_PTR_W'(1)] <= wr.ent1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RF_CNT_W'(RF_DEPTH))
    else $error("result FIFO overfilled");

  a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.cnt != 2'd0 |-> room)
    else $error("results written without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    RF_PTR_W'(wr_ptr_r - rd_ptr_r) == RF_PTR_W'(count_r))
    else $error("result FIFO pointers and count disagree");
`endif

endmodule

// ===== tb/token_ring_node_controller_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token ring node controller testbench
// Drives packet descriptors into the station with random gaps and checks
// every result against a cycle-free prediction of the station's behavior.
// ----------------------------------------------------------------------------
module token_ring_node_controller_unit_test;
  import trnc_pkg::*;

  // Station states as reported in node_state.
  localparam logic [1:0] ST_PRE   = 2'd0;
  localparam logic [1:0] ST_INIT  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_TOKEN = 2'd3;

  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [7:0]  src;
    logic [7:0]  dest;
    logic [15:0] handle;
    logic [7:0]  length;
  } pending_pkt_t;

  typedef enum {K_DATA, K_QUEUE, K_TICK, K_TOKEN, K_NOISE} item_kind_e;
  typedef enum {MODE_MIX, MODE_FILL, MODE_DRAIN} burst_mode_e;

  logic  clk;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  // Predicted station state.
  logic [1:0]   ring_state  = ST_PRE;
  logic [7:0]   ring_id     = 8'd0;
  bit           ring_is_host = 1'b0;
  logic [7:0]   ring_nodes  = 8'd0;
  logic [15:0]  ring_tokens = 16'd0;
  pending_pkt_t local_queue[$];

  // Results of the item being predicted, then all results still awaited.
  out_t step_results[$];
  out_t expected_results[$];

  bit as_host;
  bit in_idle_on    = 1'b1;
  bit out_idle_on   = 1'b1;
  bit hold_request  = 1'b0;
  int cycle_count   = 0;
  int fail_count    = 0;
  int items_sent    = 0;
  int items_effective = 0;
  int results_checked = 0;
  int rejects_seen  = 0;

  token_ring_node_controller_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Adds one packet result of the current item; status fields are filled later.
  function automatic void push_result(logic [1:0] port, logic [1:0] ptype,
                                      logic [7:0] value, logic [7:0] src,
                                      logic [7:0] dest, logic [15:0] handle,
                                      logic [7:0] length);
    out_t r;
    r            = '0;
    r.out_port   = port;
    r.out_type   = ptype;
    r.out_value  = value;
    r.out_src    = src;
    r.out_dest   = dest;
    r.out_handle = handle;
    r.out_length = length;
    if (port == PORT_REJECT) rejects_seen++;
    step_results.push_back(r);
  endfunction

  // Advances the station prediction by one item and queues its results.
  task automatic predict_station(input in_t it, output bit effect);
    out_t         r;
    pending_pkt_t e;
    effect = 1'b0;
    step_results.delete();
    case (it.operation)
      OP_RX: begin
        case (it.pkt_type)
          PT_ID: begin
            if (ring_is_host) begin
              // The id packet came around the ring: its value is the ring size.
              if (ring_state == ST_INIT) begin
                ring_state  = ST_TOKEN;
                ring_tokens = ring_tokens + 16'd1;
                ring_nodes  = it.pkt_value;
                push_result(PORT_SEND, PT_SIZE, ring_nodes, 8'd0, 8'd0, 16'd0, LEN_INIT);
              end
            end else if (ring_state == ST_PRE && it.pkt_value != 8'd0 &&
                         it.pkt_value != BCAST_ID) begin
              ring_state = ST_INIT;
              ring_id    = it.pkt_value;
              push_result(PORT_SEND, PT_ID, it.pkt_value + 8'd1, 8'd0, 8'd0, 16'd0,
                          LEN_INIT);
            end
          end
          PT_SIZE: begin
            if (!ring_is_host && ring_state == ST_INIT) begin
              ring_state = ST_WAIT;
              ring_nodes = it.pkt_value;
              push_result(PORT_SEND, PT_SIZE, it.pkt_value, 8'd0, 8'd0, 16'd0, LEN_INIT);
            end
          end
          PT_TOKEN: begin
            ring_state  = ST_TOKEN;
            ring_tokens = ring_tokens + 16'd1;
            effect      = 1'b1;
          end
          default: begin
            // Data: dropped before waiting or when it is our own packet.
            if (ring_state >= ST_WAIT && it.pkt_src != ring_id) begin
              if (it.pkt_dest == ring_id) begin
                push_result(PORT_DELIVER, PT_DATA, 8'd0, it.pkt_src, it.pkt_dest,
                            it.payload_handle, it.pkt_length);
              end else begin
                if (it.pkt_dest == BCAST_ID)
                  push_result(PORT_DELIVER, PT_DATA, 8'd0, it.pkt_src, it.pkt_dest,
                              it.payload_handle, it.pkt_length);
                push_result(PORT_SEND, PT_DATA, 8'd0, it.pkt_src, it.pkt_dest,
                            it.payload_handle, it.pkt_length);
              end
            end
          end
        endcase
      end
      OP_HOST: begin
        if (ring_state == ST_PRE) begin
          ring_state   = ST_INIT;
          ring_id      = 8'd0;
          ring_is_host = 1'b1;
          push_result(PORT_SEND, PT_ID, FIRST_ID, 8'd0, 8'd0, 16'd0, LEN_INIT);
        end
      end
      OP_QUEUE: begin
        // Requests without data bytes are ignored; a full queue rejects.
        if (it.pkt_length > LEN_HDR) begin
          if (local_queue.size() >= QUEUE_DEPTH) begin
            push_result(PORT_REJECT, PT_DATA, 8'd0, ring_id, it.pkt_dest,
                        it.payload_handle, it.pkt_length);
          end else begin
            e.src    = ring_id;
            e.dest   = it.pkt_dest;
            e.handle = it.payload_handle;
            e.length = it.pkt_length;
            local_queue.push_back(e);
            effect = 1'b1;
          end
        end
      end
      default: begin
        // Tick: the token holder sends one queued packet if any, then the token.
        if (ring_state == ST_TOKEN) begin
          ring_state = ST_WAIT;
          if (local_queue.size() > 0) begin
            e = local_queue.pop_front();
            push_result(PORT_SEND, PT_DATA, 8'd0, e.src, e.dest, e.handle, e.length);
          end
          push_result(PORT_SEND, PT_TOKEN, 8'd0, 8'd0, 8'd0, 16'd0, LEN_TOKEN);
        end
      end
    endcase
    foreach (step_results[k]) begin
      r               = step_results[k];
      r.out_last      = (k == step_results.size() - 1);
      r.node_state    = ring_state;
      r.node_id       = ring_id;
      r.ring_size_now = ring_nodes;
      r.tokens_seen   = ring_tokens;
      expected_results.push_back(r);
    end
    if (step_results.size() != 0) effect = 1'b1;
  endtask

  // Sends one item after a random gap and predicts it at its transfer.
  task automatic send_item(input in_t it);
    int gap;
    bit effect;
    gap = in_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_station(it, effect);
    items_sent++;
    if (effect) items_effective++;
  endtask

  // An item with every field random, then the operation and type forced.
  function automatic in_t make_item(logic [1:0] op, logic [1:0] ptype);
    in_t it;
    it.operation      = op;
    it.pkt_type       = ptype;
    it.pkt_value      = 8'($urandom_range(0, 255));
    it.pkt_src        = 8'($urandom_range(0, 255));
    it.pkt_dest       = 8'($urandom_range(0, 255));
    it.payload_handle = 16'($urandom_range(0, 65535));
    it.pkt_length     = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Node ids biased toward the ones the station treats specially.
  function automatic logic [7:0] pick_node();
    case ($urandom_range(0, 5))
      0:       return ring_id;
      1:       return BCAST_ID;
      2:       return ring_id + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Lengths mostly in the data range, sometimes header-only or oversize.
  function automatic logic [7:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 3));
      1:       return 8'($urandom_range(253, 255));
      default: return 8'($urandom_range(4, 252));
    endcase
  endfunction

  // Compares one result field and reports a mismatch.
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result checker: each transfer on the result side is matched in order.
  initial begin : result_checker
    out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("out_data: unexpected result %h", out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_port", 16'(want.out_port), 16'(out_data.out_port));
          check_field("out_type", 16'(want.out_type), 16'(out_data.out_type));
          check_field("out_value", 16'(want.out_value), 16'(out_data.out_value));
          check_field("out_src", 16'(want.out_src), 16'(out_data.out_src));
          check_field("out_dest", 16'(want.out_dest), 16'(out_data.out_dest));
          check_field("out_handle", want.out_handle, out_data.out_handle);
          check_field("out_length", 16'(want.out_length), 16'(out_data.out_length));
          check_field("out_last", 16'(want.out_last), 16'(out_data.out_last));
          check_field("node_state", 16'(want.node_state), 16'(out_data.node_state));
          check_field("node_id", 16'(want.node_id), 16'(out_data.node_id));
          check_field("ring_size_now", 16'(want.ring_size_now),
                      16'(out_data.ring_size_now));
          check_field("tokens_seen", want.tokens_seen, out_data.tokens_seen);
          results_checked++;
        end
      end
    end
  end

  // Result-side stall: a random wait per result, plus long holds on request.
  initial begin : result_stall
    int wait_left;
    int hold_left;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (out_valid && !out_stall)
        wait_left = out_idle_on ? $urandom_range(0, 19) : 0;
      else if (wait_left > 0 && out_valid)
        wait_left--;
      if (hold_left > 0) hold_left--;
      out_stall <= (hold_left > 0) || (wait_left > 0);
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL token_ring_node_controller_unit");
        $finish;
      end
    end
  end

  // Before initialization: data, tick and bad ids are dropped; queueing works.
  task automatic test_pre_init();
    in_t it;
    it = make_item(OP_RX, PT_DATA);
    send_item(it);
    it = make_item(OP_QUEUE, PT_DATA);
    it.pkt_length = LEN_HDR;
    send_item(it);
    it = make_item(OP_QUEUE, PT_DATA);
    it.pkt_length     = LEN_HDR + 8'd1;
    it.pkt_dest       = 8'd0;
    it.payload_handle = 16'hFFFF;
    send_item(it);
    it = make_item(OP_TICK, PT_ID);
    send_item(it);
    it = make_item(OP_RX, PT_ID);
    it.pkt_value = 8'd0;
    send_item(it);
    it.pkt_value = BCAST_ID;
    send_item(it);
    it = make_item(OP_RX, PT_SIZE);
    send_item(it);
  endtask

  // Ring initialization, either as host or as a normal station.
  task automatic test_initialize();
    in_t it;
    as_host = ($urandom_range(0, 1) == 1);
    if (as_host) begin
      it = make_item(OP_HOST, PT_ID);
      send_item(it);
      send_item(it);
      it = make_item(OP_RX, PT_SIZE);
      send_item(it);
      it = make_item(OP_RX, PT_ID);
      send_item(it);
      it = make_item(OP_RX, PT_ID);
      send_item(it);
    end else begin
      it = make_item(OP_RX, PT_ID);
      it.pkt_value = ($urandom_range(0, 1) == 1) ? 8'd254 : 8'($urandom_range(1, 254));
      send_item(it);
      it = make_item(OP_RX, PT_ID);
      it.pkt_value = 8'($urandom_range(1, 254));
      send_item(it);
      it = make_item(OP_HOST, PT_ID);
      send_item(it);
      it = make_item(OP_RX, PT_SIZE);
      send_item(it);
      it = make_item(OP_RX, PT_SIZE);
      send_item(it);
    end
  endtask

  // Token handling and the four ways a data packet is treated.
  task automatic test_data_paths();
    in_t it;
    if (ring_state != ST_TOKEN) begin
      it = make_item(OP_RX, PT_TOKEN);
      send_item(it);
    end
    it = make_item(OP_TICK, PT_DATA);
    send_item(it);
    send_item(it);
    it = make_item(OP_RX, PT_DATA);
    it.pkt_src = ring_id;
    send_item(it);
    it = make_item(OP_RX, PT_DATA);
    it.pkt_src  = ring_id ^ 8'd1;
    it.pkt_dest = ring_id;
    send_item(it);
    it = make_item(OP_RX, PT_DATA);
    it.pkt_src        = BCAST_ID;
    it.pkt_dest       = BCAST_ID;
    it.payload_handle = 16'hFFFF;
    it.pkt_length     = 8'd255;
    send_item(it);
    it = make_item(OP_RX, PT_DATA);
    it.pkt_src        = ring_id + 8'd2;
    it.pkt_dest       = ring_id + 8'd1;
    it.payload_handle = 16'd0;
    it.pkt_length     = 8'd0;
    send_item(it);
  endtask

  // Fill the send queue, overflow it once, then drain one entry.
  task automatic test_queue_full();
    in_t it;
    while (local_queue.size() < QUEUE_DEPTH) begin
      it = make_item(OP_QUEUE, PT_DATA);
      it.pkt_length = (local_queue.size() % 2 == 0) ? LEN_HDR + 8'd1 : 8'd252;
      send_item(it);
    end
    it = make_item(OP_QUEUE, PT_DATA);
    it.pkt_length = 8'd255;
    send_item(it);
    it = make_item(OP_RX, PT_TOKEN);
    send_item(it);
    it = make_item(OP_TICK, PT_DATA);
    send_item(it);
  endtask

  // Long receiver hold while broadcasts arrive back to back.
  task automatic test_backpressure();
    in_t it;
    in_idle_on   = 1'b0;
    hold_request = 1'b1;
    repeat (24) begin
      it = make_item(OP_RX, PT_DATA);
      it.pkt_src  = ring_id + 8'($urandom_range(1, 255));
      it.pkt_dest = BCAST_ID;
      send_item(it);
    end
    in_idle_on = 1'b1;
  endtask

  // Random bursts of well-formed traffic with some noise mixed in.
  task automatic test_random_traffic();
    in_t         it;
    int          start;
    int          pick;
    burst_mode_e mode;
    item_kind_e  kind;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      mode        = burst_mode_e'($urandom_range(0, 2));
      in_idle_on  = ($urandom_range(0, 4) != 0);
      out_idle_on = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(4, 40)) begin
        pick = $urandom_range(0, 99);
        case (mode)
          MODE_FILL:  kind = (pick < 70) ? K_QUEUE : K_DATA;
          MODE_DRAIN: kind = (pick < 40) ? K_TOKEN : (pick < 80) ? K_TICK : K_DATA;
          default: begin
            if (pick < 40)      kind = K_DATA;
            else if (pick < 60) kind = K_QUEUE;
            else if (pick < 75) kind = K_TICK;
            else if (pick < 85) kind = K_TOKEN;
            else                kind = K_NOISE;
          end
        endcase
        case (kind)
          K_DATA: begin
            it = make_item(OP_RX, PT_DATA);
            it.pkt_src    = pick_node();
            it.pkt_dest   = pick_node();
            it.pkt_length = pick_length();
          end
          K_QUEUE: begin
            it = make_item(OP_QUEUE, 2'($urandom_range(0, 3)));
            it.pkt_dest   = pick_node();
            it.pkt_length = pick_length();
          end
          K_TICK:  it = make_item(OP_TICK, 2'($urandom_range(0, 3)));
          K_TOKEN: it = make_item(OP_RX, PT_TOKEN);
          default: it = make_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        endcase
        send_item(it);
      end
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Main sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pre_init();
    test_initialize();
    test_data_paths();
    test_queue_full();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run as %s station: %0d items sent, %0d with an effect, %0d results checked.",
             as_host ? "host" : "normal", items_sent, items_effective, results_checked);
    $display("Tokens taken %0d, queue rejects %0d, %0d cycles.",
             ring_tokens, rejects_seen, cycle_count);
    if (fail_count == 0)
      $display("PASS token_ring_node_controller_unit");
    else
      $display("FAIL token_ring_node_controller_unit");
    $finish;
  end

endmodule
